[rtl/core/avs_pkg.sv]
// shared types and constants for the amf0 value scanner
package avs_pkg;

	localparam logic [7:0] MarkNumber = 8'h00;
	localparam logic [7:0] MarkString = 8'h02;
	localparam logic [7:0] MarkObject = 8'h03;
	localparam logic [7:0] MarkNull   = 8'h05;
	localparam logic [7:0] MarkObjEnd = 8'h09;

	typedef enum logic [2:0] {
		TK_STR_START = 3'd0,
		TK_STR_BYTE  = 3'd1,
		TK_NUMBER    = 3'd2,
		TK_NULL      = 3'd3,
		TK_OBJECT    = 3'd4,
		TK_BAD       = 3'd5,
		TK_TRUNC     = 3'd6
	} token_kind_t;

	typedef enum logic [1:0] {
		OP_NONE      = 2'd0,
		OP_EMIT      = 2'd1,
		OP_NUM_SHIFT = 2'd2,
		OP_NUM_DONE  = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		token_kind_t kind;
		logic [15:0] value;
		logic        last;
	} cmd_t;

endpackage

[rtl/core/avs_stream_if.sv]
// handshake interfaces for the byte input and the token output
interface avs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface avs_token_if;
	logic                valid;
	logic                ready;
	avs_pkg::token_kind_t token_kind;
	logic [63:0]         token_value;
	logic                string_last;

	modport source (output valid, output token_kind, output token_value, output string_last,
		input ready);
	modport sink (input valid, input token_kind, input token_value, input string_last,
		output ready);
endinterface

[rtl/core/amf0_value_scanner_core.sv]
// top level of the amf0 value scanner
//
//  channel    dir   payload                                   beat
//  in_stream  in    data_byte[7:0], end_of_buffer             one buffer byte
//  tok_stream out   token_kind[2:0], token_value[63:0],       one token
//                   string_last
//
// one byte per cycle while the command queue has room; the phase tracker in the
// front end settles each byte as it is taken, and each token passes the queue.
// the command queue holds QueueDepth entries; input stalls only when it is full.
// reset clears phase, counters, queue pointers and the output valid at once.
module amf0_value_scanner_core #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	avs_byte_if.sink    in_stream,
	avs_token_if.source tok_stream
);

	logic          push, pop, q_full, q_valid;
	avs_pkg::cmd_t push_cmd, q_head;

	avs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_stream.valid),
		.in_byte  (in_stream.data_byte),
		.in_eob   (in_stream.end_of_buffer),
		.q_full   (q_full),
		.in_ready (in_stream.ready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	avs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	avs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.tok_ready (tok_stream.ready),
		.tok_valid (tok_stream.valid),
		.tok_kind  (tok_stream.token_kind),
		.tok_value (tok_stream.token_value),
		.tok_last  (tok_stream.string_last)
	);

endmodule

[rtl/core/avs_front.sv]
// front end: accepts bytes, tracks the parse phase and issues commands
module avs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_eob,
	input  logic          q_full,
	output logic          in_ready,
	output logic          push,
	output avs_pkg::cmd_t push_cmd
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_STR_HI, PH_STR_LO, PH_STR_BODY, PH_NUM, PH_KEY_HI, PH_KEY_LO,
		PH_KEY_BODY, PH_AFTER_EMPTY, PH_VAL_MARK, PH_VSTR_HI, PH_VSTR_LO, PH_SKIP
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [15:0] rem_q, rem_d;
	logic [7:0]  hi_q, hi_d;
	logic [15:0] len;
	logic        beat;
	avs_pkg::cmd_t cmd;

	assign in_ready = !q_full;
	assign beat     = in_valid && in_ready;
	assign len      = {hi_q, in_byte};

	always_comb begin
		ph_d = ph_q;
		rem_d = rem_q;
		hi_d = hi_q;
		cmd.op = avs_pkg::OP_NONE;
		cmd.kind = avs_pkg::TK_NULL;
		cmd.value = 16'd0;
		cmd.last = 1'b0;
		case (ph_q)
			PH_IDLE: begin
				if (in_byte == avs_pkg::MarkString) begin
					ph_d = PH_STR_HI;
				end else if (in_byte == avs_pkg::MarkNumber) begin
					rem_d = 16'd8;
					ph_d = PH_NUM;
				end else if (in_byte == avs_pkg::MarkNull) begin
					cmd.op = avs_pkg::OP_EMIT;
					cmd.kind = avs_pkg::TK_NULL;
				end else if (in_byte == avs_pkg::MarkObject) begin
					ph_d = PH_KEY_HI;
				end else begin
					cmd.op = avs_pkg::OP_EMIT;
					cmd.kind = avs_pkg::TK_BAD;
				end
			end
			PH_STR_HI: begin
				hi_d = in_byte;
				ph_d = PH_STR_LO;
			end
			PH_STR_LO: begin
				cmd.op = avs_pkg::OP_EMIT;
				cmd.kind = avs_pkg::TK_STR_START;
				cmd.value = len;
				rem_d = len;
				ph_d = (len == 16'd0) ? PH_IDLE : PH_STR_BODY;
			end
			PH_STR_BODY: begin
				rem_d = rem_q - 16'd1;
				cmd.op = avs_pkg::OP_EMIT;
				cmd.kind = avs_pkg::TK_STR_BYTE;
				cmd.value = {8'd0, in_byte};
				if (rem_q == 16'd1) begin
					cmd.last = 1'b1;
					ph_d = PH_IDLE;
				end
			end
			PH_NUM: begin
				rem_d = rem_q - 16'd1;
				cmd.value = {8'd0, in_byte};
				if (rem_q == 16'd1) begin
					cmd.op = avs_pkg::OP_NUM_DONE;
					cmd.kind = avs_pkg::TK_NUMBER;
					ph_d = PH_IDLE;
				end else begin
					cmd.op = avs_pkg::OP_NUM_SHIFT;
				end
			end
			PH_KEY_HI, PH_VSTR_HI: begin
				hi_d = in_byte;
				ph_d = (ph_q == PH_KEY_HI) ? PH_KEY_LO : PH_VSTR_LO;
			end
			PH_KEY_LO: begin
				rem_d = len;
				ph_d = (len == 16'd0) ? PH_AFTER_EMPTY : PH_KEY_BODY;
			end
			PH_KEY_BODY: begin
				rem_d = rem_q - 16'd1;
				if (rem_q == 16'd1) begin
					ph_d = PH_VAL_MARK;
				end
			end
			PH_AFTER_EMPTY, PH_VAL_MARK: begin
				if (ph_q == PH_AFTER_EMPTY && in_byte == avs_pkg::MarkObjEnd) begin
					cmd.op = avs_pkg::OP_EMIT;
					cmd.kind = avs_pkg::TK_OBJECT;
					ph_d = PH_IDLE;
				end else if (in_byte == avs_pkg::MarkString) begin
					ph_d = PH_VSTR_HI;
				end else if (in_byte == avs_pkg::MarkNumber) begin
					rem_d = 16'd8;
					ph_d = PH_SKIP;
				end else begin
					ph_d = PH_KEY_HI;
				end
			end
			PH_VSTR_LO: begin
				rem_d = len;
				ph_d = (len == 16'd0) ? PH_KEY_HI : PH_SKIP;
			end
			PH_SKIP: begin
				rem_d = rem_q - 16'd1;
				if (rem_q == 16'd1) begin
					ph_d = PH_KEY_HI;
				end
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase
		// buffer ended mid-value
		if (in_eob && ph_d != PH_IDLE) begin
			cmd.op = avs_pkg::OP_EMIT;
			cmd.kind = avs_pkg::TK_TRUNC;
			cmd.value = 16'd0;
			cmd.last = 1'b0;
			ph_d = PH_IDLE;
			rem_d = 16'd0;
			hi_d = 8'd0;
		end
	end

	assign push     = beat && (cmd.op != avs_pkg::OP_NONE);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			rem_q <= 16'd0;
			hi_q <= 8'd0;
		end else if (beat) begin
			ph_q <= ph_d;
			rem_q <= rem_d;
			hi_q <= hi_d;
		end
	end

endmodule

[rtl/core/avs_queue.sv]
// small command fifo between front and back
module avs_queue #(
	parameter int Depth = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  avs_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output avs_pkg::cmd_t head
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	avs_pkg::cmd_t     mem_q [Depth];
	logic [PtrW-1:0]   wr_q, rd_q;
	logic [CntW-1:0]   cnt_q;
	logic              do_push, do_pop;

	assign full      = (cnt_q == CntW'(Depth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

[rtl/core/avs_back.sv]
// back end: gathers number bytes and drives the token output register
module avs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  avs_pkg::cmd_t        q_head,
	output logic                 pop,
	input  logic                 tok_ready,
	output logic                 tok_valid,
	output avs_pkg::token_kind_t tok_kind,
	output logic [63:0]          tok_value,
	output logic                 tok_last
);

	logic [55:0] acc_q;
	logic        out_free;
	logic        valid_q;

	assign out_free  = !valid_q || tok_ready;
	assign pop       = q_valid && (out_free || q_head.op == avs_pkg::OP_NUM_SHIFT);
	assign tok_valid = valid_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			case (q_head.op)
				avs_pkg::OP_NUM_SHIFT: begin
					acc_q <= {acc_q[47:0], q_head.value[7:0]};
				end
				avs_pkg::OP_NUM_DONE: begin
					acc_q <= {acc_q[47:0], q_head.value[7:0]};
					tok_kind <= q_head.kind;
					tok_value <= {acc_q, q_head.value[7:0]};
					tok_last <= 1'b0;
				end
				avs_pkg::OP_EMIT: begin
					tok_kind <= q_head.kind;
					tok_value <= {48'd0, q_head.value};
					tok_last <= q_head.last;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && q_head.op != avs_pkg::OP_NUM_SHIFT) begin
			valid_q <= 1'b1;
		end else if (tok_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[dv/amf0_value_scanner_core_tb.sv]
`timescale 1ns / 100ps
// testbench for amf0_value_scanner_core: drives amf0 byte streams and checks every token
module amf0_value_scanner_core_tb;

	localparam int CycleLimit = 500000;
	localparam int SettleCycles = 12;
	localparam int TargetItems = 600;

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_STR_HI, SCAN_STR_LO, SCAN_STR_BODY, SCAN_NUM, SCAN_KEY_HI, SCAN_KEY_LO,
		SCAN_KEY_BODY, SCAN_AFTER_EMPTY, SCAN_VAL_MARK, SCAN_VSTR_HI, SCAN_VSTR_LO, SCAN_SKIP
	} scan_phase_t;

	typedef struct packed {
		avs_pkg::token_kind_t kind;
		logic [63:0]          value;
		logic                 last;
	} token_t;

	typedef struct {
		logic [7:0] data;
		logic       eob;
		int         gap;
	} byte_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	avs_byte_if  in_stream ();
	avs_token_if tok_stream ();

	amf0_value_scanner_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_stream),
		.tok_stream (tok_stream)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	scan_phase_t scan_phase;
	logic [15:0] scan_left;
	logic [7:0]  scan_len_hi;
	logic [63:0] scan_num;
	logic        scan_in_obj;

	token_t     tokens_due[$];
	byte_beat_t bytes_to_send[$];
	logic [7:0] frame[$];

	int  mismatches = 0;
	int  items_queued = 0;
	int  cycle_count = 0;
	bit  src_gaps;
	bit  out_calm;
	bit  in_busy = 1'b0;
	bit  byte_taken = 1'b0;
	bit  tok_taken = 1'b0;
	int  gap_count = 0;
	int  stall_left = 0;

	task automatic clear_scan();
		scan_phase = SCAN_IDLE;
		scan_left = '0;
		scan_len_hi = '0;
		scan_num = '0;
		scan_in_obj = 1'b0;
	endtask

	task automatic add_frame_byte(input logic [7:0] b);
		frame.insert(frame.size(), b);
	endtask

	task automatic take_value_marker(input logic [7:0] b);
		if (b == avs_pkg::MarkString) begin
			scan_phase = SCAN_VSTR_HI;
		end else if (b == avs_pkg::MarkNumber) begin
			scan_left = 16'd8;
			scan_phase = SCAN_SKIP;
		end else begin
			scan_phase = SCAN_KEY_HI;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic eob);
		bit          hit;
		token_t      tok;
		logic [15:0] len;
		hit = 1'b0;
		tok = '{avs_pkg::TK_STR_START, 64'd0, 1'b0};
		len = {scan_len_hi, b};
		case (scan_phase)
			SCAN_IDLE: begin
				if (b == avs_pkg::MarkString) begin
					scan_phase = SCAN_STR_HI;
				end else if (b == avs_pkg::MarkNumber) begin
					scan_num = '0;
					scan_left = 16'd8;
					scan_phase = SCAN_NUM;
				end else if (b == avs_pkg::MarkNull) begin
					hit = 1'b1;
					tok.kind = avs_pkg::TK_NULL;
				end else if (b == avs_pkg::MarkObject) begin
					scan_in_obj = 1'b1;
					scan_phase = SCAN_KEY_HI;
				end else begin
					hit = 1'b1;
					tok.kind = avs_pkg::TK_BAD;
				end
			end
			SCAN_STR_HI: begin
				scan_len_hi = b;
				scan_phase = SCAN_STR_LO;
			end
			SCAN_STR_LO: begin
				hit = 1'b1;
				tok.kind = avs_pkg::TK_STR_START;
				tok.value = {48'd0, len};
				scan_left = len;
				scan_phase = (len == 16'd0) ? SCAN_IDLE : SCAN_STR_BODY;
			end
			SCAN_STR_BODY: begin
				scan_left = scan_left - 16'd1;
				hit = 1'b1;
				tok.kind = avs_pkg::TK_STR_BYTE;
				tok.value = {56'd0, b};
				if (scan_left == 16'd0) begin
					tok.last = 1'b1;
					scan_phase = SCAN_IDLE;
				end
			end
			SCAN_NUM: begin
				scan_num = {scan_num[55:0], b};
				scan_left = scan_left - 16'd1;
				if (scan_left == 16'd0) begin
					hit = 1'b1;
					tok.kind = avs_pkg::TK_NUMBER;
					tok.value = scan_num;
					scan_phase = SCAN_IDLE;
				end
			end
			SCAN_KEY_HI: begin
				scan_len_hi = b;
				scan_phase = SCAN_KEY_LO;
			end
			SCAN_KEY_LO: begin
				scan_left = len;
				scan_phase = (len == 16'd0) ? SCAN_AFTER_EMPTY : SCAN_KEY_BODY;
			end
			SCAN_KEY_BODY: begin
				scan_left = scan_left - 16'd1;
				if (scan_left == 16'd0) scan_phase = SCAN_VAL_MARK;
			end
			SCAN_AFTER_EMPTY: begin
				if (b == avs_pkg::MarkObjEnd) begin
					hit = 1'b1;
					tok.kind = avs_pkg::TK_OBJECT;
					scan_in_obj = 1'b0;
					scan_phase = SCAN_IDLE;
				end else begin
					take_value_marker(b);
				end
			end
			SCAN_VAL_MARK: take_value_marker(b);
			SCAN_VSTR_HI: begin
				scan_len_hi = b;
				scan_phase = SCAN_VSTR_LO;
			end
			SCAN_VSTR_LO: begin
				scan_left = len;
				scan_phase = (len == 16'd0) ? SCAN_KEY_HI : SCAN_SKIP;
			end
			SCAN_SKIP: begin
				scan_left = scan_left - 16'd1;
				if (scan_left == 16'd0) scan_phase = SCAN_KEY_HI;
			end
			default: scan_phase = SCAN_IDLE;
		endcase
		if (eob && scan_phase != SCAN_IDLE) begin
			hit = 1'b1;
			tok = '{avs_pkg::TK_TRUNC, 64'd0, 1'b0};
			clear_scan();
		end
		if (hit) tokens_due.insert(tokens_due.size(), tok);
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic eob);
		byte_beat_t beat;
		beat.data = data;
		beat.eob = eob;
		beat.gap = src_gaps ? $urandom_range(0, 19) : 0;
		bytes_to_send.insert(bytes_to_send.size(), beat);
		items_queued++;
	endtask

	task automatic build_string(input int n);
		add_frame_byte(avs_pkg::MarkString);
		add_frame_byte(n[15:8]);
		add_frame_byte(n[7:0]);
		repeat (n) add_frame_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic build_number();
		add_frame_byte(avs_pkg::MarkNumber);
		repeat (8) add_frame_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic build_object();
		int         klen;
		logic [7:0] v;
		add_frame_byte(avs_pkg::MarkObject);
		repeat ($urandom_range(0, 3)) begin
			klen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
			add_frame_byte(klen[15:8]);
			add_frame_byte(klen[7:0]);
			repeat (klen) add_frame_byte(8'($urandom_range(0, 255)));
			case ($urandom_range(0, 2))
				0: build_string($urandom_range(0, 5));
				1: build_number();
				default: begin
					do v = 8'($urandom);
					while (v == avs_pkg::MarkString || v == avs_pkg::MarkNumber ||
						v == avs_pkg::MarkObjEnd);
					add_frame_byte(v);
				end
			endcase
		end
		add_frame_byte(8'h00);
		add_frame_byte(8'h00);
		add_frame_byte(avs_pkg::MarkObjEnd);
	endtask

	task automatic send_frame(input bit chop);
		int cut;
		bit flag_end;
		cut = chop ? $urandom_range(0, frame.size() - 1) : frame.size() - 1;
		flag_end = chop || ($urandom_range(0, 3) == 0);
		for (int i = 0; i <= cut; i++) queue_byte(frame[i], flag_end && i == cut);
		frame.delete();
	endtask

	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || in_busy || tokens_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// byte driver
	always @(negedge clk) begin
		if (byte_taken) begin
			in_busy = 1'b0;
			byte_taken = 1'b0;
		end
		if (!in_busy && bytes_to_send.size() != 0) begin
			if (gap_count < bytes_to_send[0].gap) begin
				gap_count++;
			end else begin
				in_stream.data_byte <= bytes_to_send[0].data;
				in_stream.end_of_buffer <= bytes_to_send[0].eob;
				void'(bytes_to_send.pop_front());
				gap_count = 0;
				in_busy = 1'b1;
			end
		end
		in_stream.valid <= in_busy;
	end

	// token sink backpressure
	always @(negedge clk) begin
		if (tok_taken) begin
			tok_taken = 1'b0;
			stall_left = out_calm ? 0 : $urandom_range(0, 19);
		end
		if (stall_left > 0) begin
			stall_left--;
			tok_stream.ready <= 1'b0;
		end else begin
			tok_stream.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_beats
		token_t due;
		if (arst_n) begin
			if (tok_stream.valid && tok_stream.ready) begin
				tok_taken = 1'b1;
				if (tokens_due.size() == 0) begin
					$display("%0t: unexpected token: expected none, actual kind %0d value %h last %b",
						$time, tok_stream.token_kind, tok_stream.token_value,
						tok_stream.string_last);
					mismatches++;
				end else begin
					due = tokens_due.pop_front();
					if (tok_stream.token_kind !== due.kind) begin
						$display("%0t: token_kind expected %0d actual %0d", $time, due.kind,
							tok_stream.token_kind);
						mismatches++;
					end
					if (tok_stream.token_value !== due.value) begin
						$display("%0t: token_value expected %h actual %h", $time, due.value,
							tok_stream.token_value);
						mismatches++;
					end
					if (tok_stream.string_last !== due.last) begin
						$display("%0t: string_last expected %b actual %b", $time, due.last,
							tok_stream.string_last);
						mismatches++;
					end
				end
			end
			if (in_stream.valid && in_stream.ready) begin
				byte_taken = 1'b1;
				scan_byte(in_stream.data_byte, in_stream.end_of_buffer);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int         pick;
		logic [7:0] b;
		clear_scan();
		in_stream.valid = 1'b0;
		in_stream.data_byte = 8'h00;
		in_stream.end_of_buffer = 1'b0;
		tok_stream.ready = 1'b0;
		src_gaps = 1'b1;
		out_calm = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: each marker, field extremes, end of buffer cases
		queue_byte(avs_pkg::MarkNull, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(avs_pkg::MarkString, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(avs_pkg::MarkString, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h02, 1'b0);
		queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b1);
		queue_byte(avs_pkg::MarkNumber, 1'b0); queue_byte(8'h80, 1'b0);
		repeat (6) queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(avs_pkg::MarkObject, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(avs_pkg::MarkNull, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
		queue_byte(avs_pkg::MarkObjEnd, 1'b0);
		queue_byte(avs_pkg::MarkNull, 1'b1);
		queue_byte(avs_pkg::MarkString, 1'b0); queue_byte(8'hFF, 1'b1);
		wait_idle();

		// long string with no idling, counter crosses the low byte
		src_gaps = 1'b0;
		out_calm = 1'b1;
		build_string(257);
		send_frame(1'b0);

		while (items_queued < TargetItems) begin
			src_gaps = $urandom_range(0, 3) != 0;
			out_calm = $urandom_range(0, 3) == 0;
			repeat ($urandom_range(4, 12)) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					build_string($urandom_range(0, 6));
					send_frame($urandom_range(0, 6) == 0);
				end else if (pick < 40) begin
					build_number();
					send_frame($urandom_range(0, 6) == 0);
				end else if (pick < 48) begin
					queue_byte(avs_pkg::MarkNull, $urandom_range(0, 3) == 0);
				end else if (pick < 70) begin
					build_object();
					send_frame($urandom_range(0, 6) == 0);
				end else if (pick < 78) begin
					do b = 8'($urandom);
					while (b == avs_pkg::MarkNumber || b == avs_pkg::MarkString ||
						b == avs_pkg::MarkObject || b == avs_pkg::MarkNull);
					queue_byte(b, $urandom_range(0, 3) == 0);
				end else if (pick < 88) begin
					// large length header cut off by end of buffer
					add_frame_byte($urandom_range(0, 1) ? avs_pkg::MarkString :
						avs_pkg::MarkObject);
					repeat ($urandom_range(2, 6)) add_frame_byte(8'($urandom_range(0, 255)));
					send_frame(1'b1);
				end else begin
					repeat ($urandom_range(1, 6))
						queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				end
			end
			if ($urandom_range(0, 2) == 0) wait_idle();
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/avs_pkg.sv
rtl/core/avs_stream_if.sv
rtl/core/avs_front.sv
rtl/core/avs_queue.sv
rtl/core/avs_back.sv
rtl/core/amf0_value_scanner_core.sv
dv/amf0_value_scanner_core_tb.sv
